/* rtl/i2cm_pkg.sv */
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Shared types and constants for the command queue, the bus sequencer and
// the register port.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 32;
   localparam int unsigned CFG_DELAY_WIDTH = 16;
   localparam logic [CFG_DELAY_WIDTH-1:0] DELAY_RESET = 16'd500;
   localparam logic CSR_IDX_DELAY = 1'b0;

   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_READ = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,
      CMD_START = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_READ  = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   shift;
      logic         stop;
      logic         sda_in;
   } item_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       ready_res;
      logic       done_res;
      logic       acked;
      logic [7:0] read_data;
   } rsp_type;

   typedef enum logic [16:0] {
      PH_IDLE    = 17'h00001,
      PH_ST_SDA1 = 17'h00002,
      PH_ST_SCL1 = 17'h00004,
      PH_ST_SDA0 = 17'h00008,
      PH_ST_SCL0 = 17'h00010,
      PH_TX_BIT  = 17'h00020,
      PH_TX_HIGH = 17'h00040,
      PH_TX_REL  = 17'h00080,
      PH_TX_ACK  = 17'h00100,
      PH_RX_REL  = 17'h00200,
      PH_RX_HIGH = 17'h00400,
      PH_RX_LOW  = 17'h00800,
      PH_RX_ACK  = 17'h01000,
      PH_RX_END  = 17'h02000,
      PH_SP_SDA0 = 17'h04000,
      PH_SP_SCL1 = 17'h08000,
      PH_SP_SDA1 = 17'h10000
   } phase_type;

endpackage

`default_nettype wire

/* rtl/i2cm_fifo.sv */
// ----------------------------------------------------------------------------
// I2C master small queue
// A shallow register queue that decouples two sides of the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] din,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] dout,
   output logic                  empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

`default_nettype wire

/* rtl/i2cm_front.sv */
// ----------------------------------------------------------------------------
// I2C master front end
// Accepts items, decodes the command and its first shift byte, and queues
// them for the bus sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire logic              req_cmd_valid,
   input  wire logic [1:0]        req_mode,
   input  wire logic [7:0]        req_byte_in,
   input  wire logic              req_read_bit,
   input  wire logic              req_last,
   input  wire logic              req_sda_in,
   output i2cm_pkg::item_type     item,
   output logic                   item_empty,
   input  wire logic              item_pop
);

   i2cm_pkg::item_type decoded;
   logic [$bits(i2cm_pkg::item_type)-1:0] item_bits;

   always_comb begin
      decoded.kind   = i2cm_pkg::CMD_NONE;
      decoded.shift  = 8'h00;
      decoded.stop   = 1'b0;
      decoded.sda_in = req_sda_in;
      if (req_cmd_valid) begin
         unique case (req_mode)
            i2cm_pkg::MODE_START: begin
               decoded.kind  = i2cm_pkg::CMD_START;
               decoded.shift = {req_byte_in[6:0], req_read_bit};
            end
            i2cm_pkg::MODE_WRITE: begin
               decoded.kind  = i2cm_pkg::CMD_WRITE;
               decoded.shift = req_byte_in;
               decoded.stop  = req_last;
            end
            i2cm_pkg::MODE_READ: begin
               decoded.kind = i2cm_pkg::CMD_READ;
               decoded.stop = req_last;
            end
            default: begin
               decoded.kind = i2cm_pkg::CMD_NONE;
            end
         endcase
      end
   end

   i2cm_fifo #(
      .WIDTH($bits(i2cm_pkg::item_type)),
      .DEPTH(2)
   ) u_cmd_queue (
      .clock(clock),
      .reset(reset),
      .push (req_push),
      .din  (decoded),
      .full (req_full),
      .pop  (item_pop),
      .dout (item_bits),
      .empty(item_empty)
   );

   assign item = item_bits;

endmodule

`default_nettype wire

/* rtl/i2cm_back.sv */
// ----------------------------------------------------------------------------
// I2C master bus sequencer
// Steps the SCL and SDA state machine once per queued item and emits the
// pin levels and status for that step.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_back #(
   parameter int DELAY_WIDTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [i2cm_pkg::CFG_DELAY_WIDTH-1:0] delay_cycles,
   input  wire i2cm_pkg::item_type                    item,
   input  wire logic                                  item_empty,
   output logic                                       item_pop,
   output i2cm_pkg::rsp_type                          rsp,
   output logic                                       rsp_push,
   input  wire logic                                  rsp_full
);

   localparam logic [32:0] DELAY_MAX = (33'd1 << DELAY_WIDTH) - 33'd1;

   i2cm_pkg::phase_type    phase_ff, phase_in, target;
   logic [3:0]             bit_count_ff, bit_count_in;
   logic [7:0]             shift_ff, shift_in;
   logic [DELAY_WIDTH-1:0] delay_count_ff, delay_count_in;
   logic                   scl_ff, scl_in;
   logic                   sda_ff, sda_in;
   logic                   ack_ff, ack_in;
   logic [7:0]             rx_ff, rx_in;
   logic                   stop_ff, stop_in;
   logic [DELAY_WIDTH-1:0] step_len;
   logic                   step, go, done;

   assign step     = !item_empty && !rsp_full;
   assign item_pop = step;
   assign rsp_push = step;

   always_comb begin
      if ({17'b0, delay_cycles} > DELAY_MAX) begin
         step_len = DELAY_WIDTH'(DELAY_MAX);
      end else if (delay_cycles == '0) begin
         step_len = DELAY_WIDTH'(1);
      end else begin
         step_len = DELAY_WIDTH'(delay_cycles);
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      bit_count_in   = bit_count_ff;
      shift_in       = shift_ff;
      delay_count_in = delay_count_ff;
      scl_in         = scl_ff;
      sda_in         = sda_ff;
      ack_in         = ack_ff;
      rx_in          = rx_ff;
      stop_in        = stop_ff;
      target         = i2cm_pkg::PH_IDLE;
      go             = 1'b0;
      done           = 1'b0;

      if (step) begin
         if (phase_ff == i2cm_pkg::PH_IDLE) begin
            if (item.kind != i2cm_pkg::CMD_NONE) begin
               bit_count_in = 4'd0;
               shift_in     = item.shift;
               stop_in      = item.stop;
               go           = 1'b1;
               unique case (item.kind)
                  i2cm_pkg::CMD_START: target = i2cm_pkg::PH_ST_SDA1;
                  i2cm_pkg::CMD_WRITE: target = i2cm_pkg::PH_TX_BIT;
                  default:             target = i2cm_pkg::PH_RX_REL;
               endcase
            end
         end else if (delay_count_ff > DELAY_WIDTH'(1)) begin
            delay_count_in = delay_count_ff - DELAY_WIDTH'(1);
         end else begin
            go = 1'b1;
            unique case (phase_ff)
               i2cm_pkg::PH_ST_SDA1: target = i2cm_pkg::PH_ST_SCL1;
               i2cm_pkg::PH_ST_SCL1: target = i2cm_pkg::PH_ST_SDA0;
               i2cm_pkg::PH_ST_SDA0: target = i2cm_pkg::PH_ST_SCL0;
               i2cm_pkg::PH_ST_SCL0: begin
                  bit_count_in = 4'd0;
                  target       = i2cm_pkg::PH_TX_BIT;
               end
               i2cm_pkg::PH_TX_BIT: target = i2cm_pkg::PH_TX_HIGH;
               i2cm_pkg::PH_TX_HIGH: begin
                  shift_in     = {shift_ff[6:0], 1'b0};
                  bit_count_in = bit_count_ff + 4'd1;
                  if (bit_count_in >= 4'd8) begin
                     target = i2cm_pkg::PH_TX_REL;
                  end else begin
                     scl_in = 1'b0;
                     target = i2cm_pkg::PH_TX_BIT;
                  end
               end
               i2cm_pkg::PH_TX_REL: target = i2cm_pkg::PH_TX_ACK;
               i2cm_pkg::PH_TX_ACK: begin
                  if (stop_ff) begin
                     target = i2cm_pkg::PH_SP_SDA0;
                  end else begin
                     go     = 1'b0;
                     scl_in = 1'b0;
                     sda_in = 1'b1;
                     done   = 1'b1;
                  end
               end
               i2cm_pkg::PH_RX_REL:  target = i2cm_pkg::PH_RX_HIGH;
               i2cm_pkg::PH_RX_HIGH: target = i2cm_pkg::PH_RX_LOW;
               i2cm_pkg::PH_RX_LOW: begin
                  bit_count_in = bit_count_ff + 4'd1;
                  if (bit_count_in >= 4'd8) begin
                     rx_in  = shift_ff;
                     target = i2cm_pkg::PH_RX_ACK;
                  end else begin
                     target = i2cm_pkg::PH_RX_HIGH;
                  end
               end
               i2cm_pkg::PH_RX_ACK: target = i2cm_pkg::PH_RX_END;
               i2cm_pkg::PH_RX_END: begin
                  if (stop_ff) begin
                     target = i2cm_pkg::PH_SP_SDA0;
                  end else begin
                     go   = 1'b0;
                     done = 1'b1;
                  end
               end
               i2cm_pkg::PH_SP_SDA0: target = i2cm_pkg::PH_SP_SCL1;
               i2cm_pkg::PH_SP_SCL1: target = i2cm_pkg::PH_SP_SDA1;
               default: begin
                  go   = 1'b0;
                  done = 1'b1;
               end
            endcase
            if (done) begin
               phase_in       = i2cm_pkg::PH_IDLE;
               delay_count_in = '0;
            end
         end
      end

      if (go) begin
         phase_in       = target;
         delay_count_in = step_len;
         unique case (target)
            i2cm_pkg::PH_ST_SDA1: sda_in = 1'b1;
            i2cm_pkg::PH_ST_SCL1: scl_in = 1'b1;
            i2cm_pkg::PH_ST_SDA0: sda_in = 1'b0;
            i2cm_pkg::PH_ST_SCL0: scl_in = 1'b0;
            i2cm_pkg::PH_TX_BIT:  sda_in = shift_in[7];
            i2cm_pkg::PH_TX_HIGH: scl_in = 1'b1;
            i2cm_pkg::PH_TX_REL: begin
               scl_in = 1'b0;
               sda_in = 1'b1;
            end
            i2cm_pkg::PH_TX_ACK: begin
               scl_in = 1'b1;
               ack_in = !item.sda_in;
            end
            i2cm_pkg::PH_RX_REL: sda_in = 1'b1;
            i2cm_pkg::PH_RX_HIGH: begin
               scl_in   = 1'b1;
               shift_in = {shift_in[6:0], item.sda_in};
            end
            i2cm_pkg::PH_RX_LOW: scl_in = 1'b0;
            i2cm_pkg::PH_RX_ACK: begin
               sda_in = stop_in;
               scl_in = 1'b1;
            end
            i2cm_pkg::PH_RX_END, i2cm_pkg::PH_SP_SDA0: begin
               scl_in = 1'b0;
               sda_in = 1'b0;
            end
            i2cm_pkg::PH_SP_SCL1: scl_in = 1'b1;
            i2cm_pkg::PH_SP_SDA1: sda_in = 1'b1;
            default: begin
               scl_in = scl_in;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= i2cm_pkg::PH_IDLE;
         bit_count_ff   <= '0;
         shift_ff       <= '0;
         delay_count_ff <= '0;
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b1;
         ack_ff         <= 1'b0;
         rx_ff          <= '0;
         stop_ff        <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         bit_count_ff   <= bit_count_in;
         shift_ff       <= shift_in;
         delay_count_ff <= delay_count_in;
         scl_ff         <= scl_in;
         sda_ff         <= sda_in;
         ack_ff         <= ack_in;
         rx_ff          <= rx_in;
         stop_ff        <= stop_in;
      end
   end

   always_comb begin
      rsp.scl_out   = scl_in;
      rsp.sda_out   = sda_in;
      rsp.ready_res = (phase_in == i2cm_pkg::PH_IDLE);
      rsp.done_res  = done;
      rsp.acked     = ack_in;
      rsp.read_data = rx_in;
   end

endmodule

`default_nettype wire

/* rtl/i2c_master_byte_engine_core.sv */
// ----------------------------------------------------------------------------
// I2C master byte engine
// Bus sequencer for start, write and read byte commands, one item per step.
// ----------------------------------------------------------------------------
// Each item on the req_ channel is one clock step of the I2C sequencer. It
// carries an optional byte command, which is taken only while the engine is
// idle, and the sampled SDA level. Every item yields exactly one item on the
// rsp_ channel with the driven SCL and SDA levels, the ready and done flags,
// the last acknowledge and the last received byte.
// The front end decodes items into a two-entry command queue; the sequencer
// takes one queued item per cycle while the result queue is not full and
// writes its result into that two-entry queue, whose head drives the rsp_
// ports; a result is queued at the same edge that accepts its item.
// When the consumer stops popping, the result queue fills, the sequencer
// holds its state, and req_full rises once the command queue is full; no
// item is lost. Reset empties both queues, puts the bus in idle with SCL and
// SDA released, and loads delay_cycles with 500. The delay_cycles register
// lies at byte address 0 and sets the clock steps per half-bit phase;
// it should be written only while the engine is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_engine_core #(
   parameter int DELAY_WIDTH = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_push,
   output logic                                      req_full,
   input  wire logic                                 req_cmd_valid,
   input  wire logic [1:0]                           req_mode,
   input  wire logic [7:0]                           req_byte_in,
   input  wire logic                                 req_read_bit,
   input  wire logic                                 req_last,
   input  wire logic                                 req_sda_in,
   output logic                                      rsp_empty,
   input  wire logic                                 rsp_pop,
   output logic                                      rsp_scl_out,
   output logic                                      rsp_sda_out,
   output logic                                      rsp_ready_res,
   output logic                                      rsp_done_res,
   output logic                                      rsp_acked,
   output logic [7:0]                                rsp_read_data,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [i2cm_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  wire logic [i2cm_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [i2cm_pkg::CSR_DATA_WIDTH-1:0]       csr_prdata,
   output logic                                      csr_pready
);

   logic [i2cm_pkg::CFG_DELAY_WIDTH-1:0] delay_ff, delay_in;
   i2cm_pkg::item_type                   item;
   logic                                 item_empty, item_pop;
   i2cm_pkg::rsp_type                    rsp_next, rsp_head;
   logic [$bits(i2cm_pkg::rsp_type)-1:0] rsp_bits;
   logic                                 rsp_push, rsp_full;
   logic                                 csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      delay_in = delay_ff;
      if (csr_write && (csr_paddr[2] == i2cm_pkg::CSR_IDX_DELAY)) begin
         delay_in = csr_pwdata[i2cm_pkg::CFG_DELAY_WIDTH-1:0];
      end
      csr_prdata = '0;
      if (csr_paddr[2] == i2cm_pkg::CSR_IDX_DELAY) begin
         csr_prdata = {{(i2cm_pkg::CSR_DATA_WIDTH - i2cm_pkg::CFG_DELAY_WIDTH){1'b0}},
                       delay_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= i2cm_pkg::DELAY_RESET;
      end else begin
         delay_ff <= delay_in;
      end
   end

   i2cm_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_cmd_valid(req_cmd_valid),
      .req_mode     (req_mode),
      .req_byte_in  (req_byte_in),
      .req_read_bit (req_read_bit),
      .req_last     (req_last),
      .req_sda_in   (req_sda_in),
      .item         (item),
      .item_empty   (item_empty),
      .item_pop     (item_pop)
   );

   i2cm_back #(
      .DELAY_WIDTH(DELAY_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .delay_cycles(delay_ff),
      .item        (item),
      .item_empty  (item_empty),
      .item_pop    (item_pop),
      .rsp         (rsp_next),
      .rsp_push    (rsp_push),
      .rsp_full    (rsp_full)
   );

   i2cm_fifo #(
      .WIDTH($bits(i2cm_pkg::rsp_type)),
      .DEPTH(2)
   ) u_rsp_queue (
      .clock(clock),
      .reset(reset),
      .push (rsp_push),
      .din  (rsp_next),
      .full (rsp_full),
      .pop  (rsp_pop),
      .dout (rsp_bits),
      .empty(rsp_empty)
   );

   assign rsp_head      = rsp_bits;
   assign rsp_scl_out   = rsp_head.scl_out;
   assign rsp_sda_out   = rsp_head.sda_out;
   assign rsp_ready_res = rsp_head.ready_res;
   assign rsp_done_res  = rsp_head.done_res;
   assign rsp_acked     = rsp_head.acked;
   assign rsp_read_data = rsp_head.read_data;

endmodule

`default_nettype wire
